FILE: rtl/core/tglht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tile grid hit table package
// Shared types, operation codes and status codes.
// ----------------------------------------------------------------------------
package tglht_pkg;

    localparam int MaxEntriesDefault = 64;

    typedef enum logic [2:0] {
        FN_CLEAR  = 3'd0,
        FN_LOAD   = 3'd1,
        FN_REMOVE = 3'd2,
        FN_HIT    = 3'd3,
        FN_NEXT   = 3'd4,
        FN_PREV   = 3'd5,
        FN_RSVD6  = 3'd6,
        FN_RSVD7  = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_AREA_X = 3'd0,
        CFG_AREA_Y = 3'd1,
        CFG_AREA_W = 3'd2,
        CFG_AREA_H = 3'd3,
        CFG_GAP    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]         func;
        logic [31:0]        window_id;
        logic               last_of_list;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  hit_index;
        logic [31:0] focused_id;
        logic [3:0]  grid_columns;
        logic [3:0]  grid_rows;
        logic [6:0]  entry_total;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_LAY_COLS,
        S_LAY_ROWS,
        S_LAY_CHK,
        S_LAY_DIVW,
        S_LAY_DIVH,
        S_LAY_DONE,
        S_RM_RD,
        S_RM_CMP,
        S_RM_SHRD,
        S_RM_SHWR,
        S_HIT_STEP,
        S_FID_RD,
        S_FID_WAIT,
        S_OUT
    } state_t;

endpackage : tglht_pkg
`default_nettype wire

FILE: rtl/core/tglht_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module tglht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule : tglht_ram
`default_nettype wire

FILE: rtl/core/tglht_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 16 by 4 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tglht_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] dividend,
    input  wire logic [3:0]  divisor,
    output logic             done,
    output logic [15:0]      quotient
);

    logic [15:0] quo_reg, quo_next;
    logic [4:0]  rem_reg, rem_next;
    logic [3:0]  dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [5:0]  trial;
    logic [15:0] step_quo;
    logic [4:0]  step_rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // The divisor is held from the start, so a new division may be started
    // in the same cycle as the last step of the previous one.
    always_comb
    begin
        trial = {rem_reg, quo_reg[15]};
        if (trial >= {2'b00, dvs_reg})
        begin
            step_rem = 5'(trial - {2'b00, dvs_reg});
            step_quo = {quo_reg[14:0], 1'b1};
        end
        else
        begin
            step_rem = trial[4:0];
            step_quo = {quo_reg[14:0], 1'b0};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd16;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = step_rem;
            quo_next = step_quo;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign done     = busy_reg && (cnt_reg == 5'd1);
    assign quotient = step_quo;

endmodule : tglht_div
`default_nettype wire

FILE: rtl/core/tile_grid_layout_hit_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tile grid layout hit table
// Ordered window id table laid out as a near-square tile grid.
// ----------------------------------------------------------------------------
// One transaction at a time. Every operation first redoes the layout: the
// column count is found by stepping up one per cycle, and the rows and both
// cell sizes come from one shared serial divider. A remove walks the table
// through the single RAM port, reading and then comparing each entry in turn,
// moves the later entries down with a read and a write each and lays out
// again; a hit test steps one tile per cycle. A result waits in an output
// register, so the next transaction is taken while it is pending; a new
// result is not written over it before it is delivered.
module tile_grid_layout_hit_table
    import tglht_pkg::*;
#(
    parameter int MAX_ENTRIES = MaxEntriesDefault
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire cfg_item_t cfg_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // configuration
    logic signed [15:0] area_x_reg, area_y_reg;
    logic [14:0]        area_w_reg, area_h_reg;
    logic [11:0]        gap_reg;

    state_t      state_reg, state_next;
    in_item_t    item_reg, item_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] load_reg, load_next;
    logic [AW-1:0] focus_reg, focus_next;
    logic [3:0]  cols_reg, cols_next;
    logic [3:0]  rows_reg, rows_next;
    logic [14:0] cw_reg, cw_next;
    logic [14:0] ch_reg, ch_next;
    logic        gvalid_reg, gvalid_next;
    logic [1:0]  lay_reg, lay_next;
    logic [1:0]  status_reg, status_next;
    logic [5:0]  hit_reg, hit_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [3:0]  hc_reg, hc_next;
    logic signed [17:0] tx_reg, tx_next, ty_reg, ty_next;
    logic        relay_reg, relay_next;
    logic        out_valid_reg;
    out_item_t   out_reg, out_next;
    logic [31:0] hold_reg, hold_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;

    logic          div_start, div_done;
    logic [15:0]   div_a, div_q;
    logic [3:0]    div_b;

    logic [18:0] need_w, need_h;
    logic signed [18:0] wrem, hrem;
    logic signed [18:0] px, py;

    tglht_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    tglht_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_x_reg <= '0;
            area_y_reg <= '0;
            area_w_reg <= 15'd1;
            area_h_reg <= 15'd1;
            gap_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_data.index)
                CFG_AREA_X: area_x_reg <= cfg_data.data[15:0];
                CFG_AREA_Y: area_y_reg <= cfg_data.data[15:0];
                CFG_AREA_W: area_w_reg <= cfg_data.data[14:0];
                CFG_AREA_H: area_h_reg <= cfg_data.data[14:0];
                CFG_GAP:    gap_reg    <= cfg_data.data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            load_reg      <= '0;
            focus_reg     <= '0;
            cols_reg      <= '0;
            rows_reg      <= '0;
            cw_reg        <= '0;
            ch_reg        <= '0;
            gvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            load_reg   <= load_next;
            focus_reg  <= focus_next;
            cols_reg   <= cols_next;
            rows_reg   <= rows_next;
            cw_reg     <= cw_next;
            ch_reg     <= ch_next;
            gvalid_reg <= gvalid_next;
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        lay_reg    <= lay_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
        idx_reg    <= idx_next;
        hc_reg     <= hc_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        relay_reg  <= relay_next;
        out_reg    <= out_next;
        hold_reg   <= hold_next;
    end

    // Layout checks on the current grid size.
    assign need_w = 19'({gap_reg, 1'b0}) + 19'(cols_reg);
    assign need_h = 19'({gap_reg, 1'b0}) + 19'(rows_reg);
    assign wrem   = 19'(area_w_reg) - 19'(gap_reg) * 19'(cols_reg + 4'd1);
    assign hrem   = 19'(area_h_reg) - 19'(gap_reg) * 19'(rows_reg + 4'd1);
    assign px     = 19'(item_reg.point_x);
    assign py     = 19'(item_reg.point_y);

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        count_next  = count_reg;
        load_next   = load_reg;
        focus_next  = focus_reg;
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        cw_next     = cw_reg;
        ch_next     = ch_reg;
        gvalid_next = gvalid_reg;
        lay_next    = lay_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        idx_next    = idx_reg;
        hc_next     = hc_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        relay_next  = relay_reg;
        out_next    = out_reg;
        hold_next   = hold_reg;
        ram_we      = 1'b0;
        ram_addr    = focus_reg;
        ram_wdata   = item_reg.window_id;
        div_start   = 1'b0;
        div_a       = '0;
        div_b       = cols_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    item_next   = in_data;
                    relay_next  = 1'b0;
                    hit_next    = '0;
                    status_next = ST_OK;
                    cols_next   = '0;
                    state_next  = S_LAY_COLS;
                end
            end
            // Column count: smallest c with c*c >= n.
            S_LAY_COLS:
            begin
                gvalid_next = 1'b0;
                cw_next     = '0;
                ch_next     = '0;
                if (count_reg == '0)
                begin
                    rows_next  = '0;
                    lay_next   = ST_OK;
                    state_next = S_LAY_DONE;
                end
                else if (8'(cols_reg) * 8'(cols_reg) < 8'(count_reg))
                begin
                    cols_next = cols_reg + 4'd1;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = 16'(count_reg) + 16'(cols_reg) - 16'd1;
                    state_next = S_LAY_ROWS;
                end
            end
            S_LAY_ROWS:
            begin
                if (div_done)
                begin
                    rows_next  = div_q[3:0];
                    state_next = S_LAY_CHK;
                end
            end
            S_LAY_CHK:
            begin
                if (19'(area_w_reg) <= need_w || 19'(area_h_reg) <= need_h
                    || wrem < $signed(19'(cols_reg)) || hrem < $signed(19'(rows_reg)))
                begin
                    lay_next   = ST_INVALID;
                    state_next = S_LAY_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = 16'(wrem);
                    state_next = S_LAY_DIVW;
                end
            end
            S_LAY_DIVW:
            begin
                if (div_done)
                begin
                    cw_next    = div_q[14:0];
                    div_start  = 1'b1;
                    div_a      = 16'(hrem);
                    div_b      = rows_reg;
                    state_next = S_LAY_DIVH;
                end
            end
            S_LAY_DIVH:
            begin
                div_b = rows_reg;
                if (div_done)
                begin
                    ch_next     = div_q[14:0];
                    gvalid_next = 1'b1;
                    lay_next    = ST_OK;
                    state_next  = S_LAY_DONE;
                end
            end
            S_LAY_DONE:
            begin
                if (relay_reg)
                begin
                    status_next = lay_reg;
                    state_next  = S_FID_RD;
                end
                else
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                relay_next = 1'b1;
                state_next = S_FID_RD;
                case (item_reg.func)
                    FN_CLEAR:
                    begin
                        count_next = '0;
                        load_next  = '0;
                        focus_next = '0;
                        cols_next  = '0;
                        state_next = S_LAY_COLS;
                    end
                    FN_LOAD:
                    begin
                        if (load_reg >= CW'(MAX_ENTRIES))
                        begin
                            load_next   = '0;
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_addr  = load_reg[AW-1:0];
                            load_next = load_reg + 1'b1;
                            if (item_reg.last_of_list)
                            begin
                                count_next = load_reg + 1'b1;
                                load_next  = '0;
                                if (CW'(focus_reg) >= load_reg + 1'b1 && focus_reg != '0)
                                begin
                                    focus_next = AW'(load_reg);
                                end
                                cols_next  = '0;
                                state_next = S_LAY_COLS;
                            end
                        end
                    end
                    FN_REMOVE:
                    begin
                        status_next = ST_NOT_FOUND;
                        idx_next    = '0;
                        state_next  = S_RM_RD;
                    end
                    FN_HIT:
                    begin
                        idx_next = '0;
                        hc_next  = '0;
                        tx_next  = 18'(area_x_reg) + 18'(gap_reg);
                        ty_next  = 18'(area_y_reg) + 18'(gap_reg);
                        if (count_reg == '0)
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (!gvalid_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_HIT_STEP;
                        end
                    end
                    FN_NEXT:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (CW'(focus_reg) + 1'b1 >= count_reg)
                        begin
                            focus_next = '0;
                        end
                        else
                        begin
                            focus_next = focus_reg + 1'b1;
                        end
                    end
                    FN_PREV:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (focus_reg == '0)
                        begin
                            focus_next = AW'(count_reg - 1'b1);
                        end
                        else
                        begin
                            focus_next = focus_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = ST_INVALID;
                    end
                endcase
            end
            // Search for the first match, reading and then comparing each entry.
            S_RM_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = S_FID_RD;
                end
                else
                begin
                    ram_addr   = idx_reg[AW-1:0];
                    state_next = S_RM_CMP;
                end
            end
            S_RM_CMP:
            begin
                if (ram_rdata == item_reg.window_id)
                begin
                    state_next = S_RM_SHRD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RM_RD;
                end
            end
            S_RM_SHRD:
            begin
                if (idx_reg + 1'b1 < count_reg)
                begin
                    ram_addr   = AW'(idx_reg + 1'b1);
                    state_next = S_RM_SHWR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (CW'(focus_reg) >= count_reg - 1'b1 && focus_reg != '0)
                    begin
                        focus_next = (count_reg > CW'(1)) ? AW'(count_reg - 2'd2) : '0;
                    end
                    cols_next  = '0;
                    state_next = S_LAY_COLS;
                end
            end
            S_RM_SHWR:
            begin
                ram_we     = 1'b1;
                ram_addr   = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = S_RM_SHRD;
            end
            // Walk the tiles in order, tracking the tile origin.
            S_HIT_STEP:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = S_FID_RD;
                end
                else if (px >= 19'(tx_reg) && px < 19'(tx_reg) + $signed(19'(cw_reg))
                         && py >= 19'(ty_reg) && py < 19'(ty_reg) + $signed(19'(ch_reg)))
                begin
                    status_next = ST_OK;
                    hit_next    = 6'(idx_reg);
                    state_next  = S_FID_RD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (hc_reg + 4'd1 == cols_reg)
                    begin
                        hc_next = '0;
                        tx_next = 18'(area_x_reg) + 18'(gap_reg);
                        ty_next = ty_reg + 18'(ch_reg) + 18'(gap_reg);
                    end
                    else
                    begin
                        hc_next = hc_reg + 4'd1;
                        tx_next = tx_reg + 18'(cw_reg) + 18'(gap_reg);
                    end
                end
            end
            S_FID_RD:
            begin
                ram_addr   = focus_reg;
                state_next = S_FID_WAIT;
            end
            S_FID_WAIT:
            begin
                hold_next  = (count_reg != '0 && CW'(focus_reg) < count_reg) ? ram_rdata : '0;
                state_next = S_OUT;
            end
            // Wait here while the previous result is still pending.
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.status       = status_reg;
                    out_next.hit_index    = hit_reg;
                    out_next.focused_id   = hold_reg;
                    out_next.grid_columns = cols_reg;
                    out_next.grid_rows    = rows_reg;
                    out_next.entry_total  = 7'(count_reg);
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule : tile_grid_layout_hit_table
`default_nettype wire

FILE: rtl/core/tglht_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tile grid hit table checker
// Port-level checks on the transaction channels.
// ----------------------------------------------------------------------------
module tglht_checker
    import tglht_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // The block is busy in the cycle after it takes an input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

    // A pending result holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");

    // Rows never exceed columns in a near-square grid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.grid_rows <= out_data.grid_columns))
        else $error("rows exceed columns");

endmodule : tglht_checker

bind tile_grid_layout_hit_table tglht_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

FILE: tb/sv/tile_grid_layout_hit_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile grid layout hit table testbench
// Drives load, remove, hit test, focus and clear operations over several area
// settings, predicts each result with an independent model of the table and
// grid, and checks each field against it, or against a typed row's result.
// ----------------------------------------------------------------------------
module tile_grid_layout_hit_table_test;
    import tglht_pkg::*;

    localparam int TABLE_DEPTH = MaxEntriesDefault;
    localparam int STALL_LIMIT = 6000;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct {
        func_t       func;
        logic [31:0] wid;
        logic        last;
        logic [15:0] px;
        logic [15:0] py;
        bit          typed;
        out_item_t   result;
    } op_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_item_t cfg_data;

    tile_grid_layout_hit_table u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Table and grid state as the block should hold it.
    logic [31:0] id_mem [TABLE_DEPTH];
    int entries;
    int loaded;
    int focus;
    int cols;
    int rows;
    int cell_w;
    int cell_h;
    bit grid_ok;
    int org_x;
    int org_y;
    int span_w;
    int span_h;
    int gap;

    out_item_t pending_results[$];
    int  mismatches;
    bit  quiet;
    int  stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic status_t redo_layout();
        grid_ok = 1'b0;
        cell_w = 0;
        cell_h = 0;
        cols = 0;
        rows = 0;
        if (entries == 0)
            return ST_OK;
        while (cols * cols < entries)
            cols++;
        rows = (entries + cols - 1) / cols;
        if (span_w <= 2 * gap + cols || span_h <= 2 * gap + rows)
            return ST_INVALID;
        if (span_w - gap * (cols + 1) < cols || span_h - gap * (rows + 1) < rows)
            return ST_INVALID;
        cell_w = (span_w - gap * (cols + 1)) / cols;
        cell_h = (span_h - gap * (rows + 1)) / rows;
        grid_ok = 1'b1;
        return ST_OK;
    endfunction

    function automatic void pull_focus_back();
        if (focus >= entries && focus != 0)
            focus = (entries != 0) ? entries - 1 : 0;
    endfunction

    function automatic out_item_t apply_op(in_item_t op);
        out_item_t res;
        status_t   st;
        int        hit;
        int        px;
        int        py;
        int        tx;
        int        ty;
        st = ST_OK;
        hit = 0;
        px = $signed(op.point_x);
        py = $signed(op.point_y);
        void'(redo_layout());
        case (func_t'(op.func))
            FN_CLEAR:
            begin
                entries = 0;
                loaded = 0;
                focus = 0;
                st = redo_layout();
            end
            FN_LOAD:
            begin
                if (loaded >= TABLE_DEPTH)
                begin
                    loaded = 0;
                    st = ST_FULL;
                end
                else
                begin
                    id_mem[loaded] = op.window_id;
                    loaded++;
                    if (op.last_of_list)
                    begin
                        entries = loaded;
                        loaded = 0;
                        pull_focus_back();
                        st = redo_layout();
                    end
                end
            end
            FN_REMOVE:
            begin
                st = ST_NOT_FOUND;
                for (int i = 0; i < entries; i++)
                begin
                    if (id_mem[i] == op.window_id)
                    begin
                        for (int k = i; k + 1 < entries; k++)
                            id_mem[k] = id_mem[k + 1];
                        entries--;
                        pull_focus_back();
                        st = redo_layout();
                        break;
                    end
                end
            end
            FN_HIT:
            begin
                if (entries == 0)
                    st = ST_INVALID;
                else if (!grid_ok)
                    st = ST_NOT_FOUND;
                else
                begin
                    st = ST_NOT_FOUND;
                    for (int i = 0; i < entries; i++)
                    begin
                        tx = org_x + gap + (i % cols) * (cell_w + gap);
                        ty = org_y + gap + (i / cols) * (cell_h + gap);
                        if (px >= tx && px < tx + cell_w && py >= ty && py < ty + cell_h)
                        begin
                            st = ST_OK;
                            hit = i;
                            break;
                        end
                    end
                end
            end
            FN_NEXT:
            begin
                if (entries == 0)
                    st = ST_INVALID;
                else
                    focus = (focus + 1) % entries;
            end
            FN_PREV:
            begin
                if (entries == 0)
                    st = ST_INVALID;
                else
                    focus = (focus + entries - 1) % entries;
            end
            default: st = ST_INVALID;
        endcase
        res.status = st;
        res.hit_index = hit[5:0];
        res.focused_id = (entries != 0 && focus < entries) ? id_mem[focus] : 32'd0;
        res.grid_columns = cols[3:0];
        res.grid_rows = rows[3:0];
        res.entry_total = entries[6:0];
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send(in_item_t op, bit typed, out_item_t typed_result);
        out_item_t predicted;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_data <= op;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_op(op);
        pending_results.push_back(typed ? typed_result : predicted);
        @(negedge clk);
    endtask

    task automatic send_op(func_t f, logic [31:0] wid, logic [31:0] last, logic [31:0] px,
                           logic [31:0] py);
        in_item_t op;
        op.func = f;
        op.window_id = wid;
        op.last_of_list = last[0];
        op.point_x = px[15:0];
        op.point_y = py[15:0];
        send(op, 1'b0, '0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_data <= '{index: idx, data: value};
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_AREA_X: org_x = $signed(value[15:0]);
            CFG_AREA_Y: org_y = $signed(value[15:0]);
            CFG_AREA_W: span_w = value[14:0];
            CFG_AREA_H: span_h = value[14:0];
            CFG_GAP:    gap = value[11:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_area(int x, int y, int w, int h, int g);
        drain();
        write_reg(CFG_AREA_X, {16'($urandom_range(0, 65535)), x[15:0]});
        write_reg(CFG_AREA_Y, {16'($urandom_range(0, 65535)), y[15:0]});
        write_reg(CFG_AREA_W, {17'($urandom_range(0, 131071)), w[14:0]});
        write_reg(CFG_AREA_H, {17'($urandom_range(0, 131071)), h[14:0]});
        write_reg(CFG_GAP, {20'($urandom_range(0, 1048575)), g[11:0]});
        cfg_valid <= 1'b0;
    endtask

    task automatic random_burst(int budget);
        int sent;
        int n;
        int i;
        int tx;
        int ty;
        logic [31:0] base;
        sent = 0;
        while (sent < budget)
        begin
            n = $urandom_range(0, 99);
            if (n < 20)
            begin
                // A whole list; now and then one that overflows the table.
                n = $urandom_range(0, 19);
                if (n == 0)
                    n = 65 + $urandom_range(0, 1);
                else if (n < 3)
                    n = $urandom_range(40, 64);
                else
                    n = $urandom_range(1, 10);
                base = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 7);
                for (i = 0; i < n; i++)
                    send_op(FN_LOAD, ($urandom_range(0, 3) == 0) ? base : $urandom(),
                            32'(i == n - 1 && n <= TABLE_DEPTH), $urandom(), $urandom());
                sent += n;
            end
            else if (n < 42)
            begin
                void'(redo_layout());
                if (grid_ok && $urandom_range(0, 4) != 0)
                begin
                    i = $urandom_range(0, entries - 1);
                    tx = org_x + gap + (i % cols) * (cell_w + gap);
                    ty = org_y + gap + (i / cols) * (cell_h + gap);
                    case ($urandom_range(0, 5))
                        0: tx = tx - 1;
                        1: tx = tx + cell_w;
                        2: ty = ty + cell_h;
                        3: ty = ty - 1;
                        default:
                        begin
                            tx = tx + $urandom_range(0, cell_w - 1);
                            ty = ty + $urandom_range(0, cell_h - 1);
                        end
                    endcase
                    send_op(FN_HIT, $urandom(), $urandom(), tx, ty);
                end
                else
                    send_op(FN_HIT, $urandom(), $urandom(), $urandom(), $urandom());
                sent++;
            end
            else if (n < 56)
            begin
                if (entries != 0 && $urandom_range(0, 9) < 7)
                    send_op(FN_REMOVE, id_mem[$urandom_range(0, entries - 1)], $urandom(),
                            $urandom(), $urandom());
                else
                    send_op(FN_REMOVE, $urandom(), $urandom(), $urandom(), $urandom());
                sent++;
            end
            else if (n < 86)
            begin
                send_op((n < 72) ? FN_NEXT : FN_PREV, $urandom(), $urandom(), $urandom(),
                        $urandom());
                sent++;
            end
            else if (n < 90)
            begin
                send_op(FN_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
                sent++;
            end
            else
            begin
                send_op(func_t'($urandom_range(0, 7)), $urandom(), $urandom(), $urandom(),
                        $urandom());
                sent++;
            end
        end
    endtask

    initial
    begin
        op_row_t rows_in[$];
        in_item_t op;
        mismatches = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        entries = 0;
        loaded = 0;
        focus = 0;
        org_x = 0;
        org_y = 0;
        span_w = 1;
        span_h = 1;
        gap = 0;
        void'(redo_layout());
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        rows_in = '{
            '{FN_NEXT, 32'h0, 1'b0, 16'h0, 16'h0, 1'b1, '{ST_INVALID, 0, 0, 0, 0, 0}},
            '{FN_PREV, 32'h0, 1'b1, 16'h0, 16'h0, 1'b1, '{ST_INVALID, 0, 0, 0, 0, 0}},
            '{FN_HIT, 32'h0, 1'b0, 16'h7fff, 16'h8000, 1'b1, '{ST_INVALID, 0, 0, 0, 0, 0}},
            '{FN_RSVD6, 32'hffffffff, 1'b1, 16'hffff, 16'hffff, 1'b1,
              '{ST_INVALID, 0, 0, 0, 0, 0}},
            '{FN_RSVD7, 32'h0, 1'b0, 16'h0, 16'h0, 1'b1, '{ST_INVALID, 0, 0, 0, 0, 0}},
            '{FN_REMOVE, 32'h5, 1'b0, 16'h0, 16'h0, 1'b1, '{ST_NOT_FOUND, 0, 0, 0, 0, 0}},
            // One id in a one-pixel area: the grid is degenerate.
            '{FN_LOAD, 32'hffffffff, 1'b1, 16'h0, 16'h0, 1'b1,
              '{ST_INVALID, 0, 32'hffffffff, 1, 1, 1}},
            '{FN_HIT, 32'h0, 1'b0, 16'h8000, 16'h7fff, 1'b1,
              '{ST_NOT_FOUND, 0, 32'hffffffff, 1, 1, 1}},
            // An uncommitted load replaces the focused entry at once.
            '{FN_LOAD, 32'h0, 1'b0, 16'h0, 16'h0, 1'b1, '{ST_OK, 0, 32'h0, 1, 1, 1}},
            '{FN_LOAD, 32'h1, 1'b0, 16'h0, 16'h0, 1'b0, '0},
            '{FN_LOAD, 32'h2, 1'b1, 16'h0, 16'h0, 1'b0, '0},
            '{FN_NEXT, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0, '0},
            '{FN_NEXT, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0, '0},
            '{FN_PREV, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0, '0},
            '{FN_NEXT, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0, '0},
            '{FN_REMOVE, 32'h2, 1'b0, 16'h0, 16'h0, 1'b0, '0},
            '{FN_REMOVE, 32'h12345678, 1'b1, 16'h0, 16'h0, 1'b0, '0},
            '{FN_HIT, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0, '0},
            '{FN_CLEAR, 32'hffffffff, 1'b1, 16'h0, 16'h0, 1'b1, '{ST_OK, 0, 0, 0, 0, 0}},
            '{FN_LOAD, 32'h80000000, 1'b1, 16'h0, 16'h0, 1'b0, '0},
            '{FN_CLEAR, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0, '0}
        };
        foreach (rows_in[i])
        begin
            op.func = rows_in[i].func;
            op.window_id = rows_in[i].wid;
            op.last_of_list = rows_in[i].last;
            op.point_x = rows_in[i].px;
            op.point_y = rows_in[i].py;
            send(op, rows_in[i].typed, rows_in[i].result);
        end

        set_area(0, 0, 640, 480, 4);
        random_burst(60);
        // Let the pipeline run dry once in the middle of a phase.
        drain();
        random_burst(70);
        set_area(-32768, -32768, 32767, 32767, 0);
        random_burst(130);
        set_area(32767, 32767, 1, 1, 4095);
        random_burst(60);
        set_area(-100, 200, 800, 600, 10);
        random_burst(130);
        set_area(-1000, -1000, 2000, 37, 1);
        random_burst(120);
        drain();
        write_reg(CFG_UNUSED, $urandom());
        cfg_valid <= 1'b0;
        set_area(100, -50, 300, 200, 2);
        random_burst(60);
        quiet = 1'b1;
        random_burst(80);

        drain();
        repeat (400) @(negedge clk);
        if (mismatches == 0)
            $display("PASS tile_grid_layout_hit_table");
        else
            $display("FAIL tile_grid_layout_hit_table");
        $finish;
    end

    // Result side stalls in bursts until the final quiet stretch.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk);
            if (!quiet)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no transaction outstanding", $time);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                    report("status", 32'(out_data.status), 32'(want.status));
                if (out_data.hit_index !== want.hit_index)
                    report("hit_index", 32'(out_data.hit_index), 32'(want.hit_index));
                if (out_data.focused_id !== want.focused_id)
                    report("focused_id", out_data.focused_id, want.focused_id);
                if (out_data.grid_columns !== want.grid_columns)
                    report("grid_columns", 32'(out_data.grid_columns),
                           32'(want.grid_columns));
                if (out_data.grid_rows !== want.grid_rows)
                    report("grid_rows", 32'(out_data.grid_rows), 32'(want.grid_rows));
                if (out_data.entry_total !== want.entry_total)
                    report("entry_total", 32'(out_data.entry_total),
                           32'(want.entry_total));
            end
        end
    end

    // Watchdog: too long without any accepted transaction ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL tile_grid_layout_hit_table");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial stall_cycles = 0;

endmodule
